[design/phe_pkg.sv]
package phe_pkg;

   localparam int MAX_PAIRS_DEF = 64;
   localparam int KEY_WIDTH_DEF = 32;

   localparam int DATA_W     = 32;
   localparam int SIFT_W     = 10;
   localparam int REQ_DATA_W = 2 * DATA_W;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * DATA_W - SIFT_W;

   localparam logic [SIFT_W-1:0] SIFT_MAX = '1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_BUILD_INIT,
      OP_READ_IDX,
      OP_SIFT_LOAD,
      OP_LEVEL,
      OP_CMP_L,
      OP_CMP_R,
      OP_DESCEND,
      OP_IDX_DEC,
      OP_EXT_INIT,
      OP_EXT_R1,
      OP_EXT_R2,
      OP_EXT_W,
      OP_OUT_INIT,
      OP_OUT_RD,
      OP_OUT_LD,
      OP_CLEAR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      in_ready;
   } cmd_type;

   typedef struct packed {
      logic idx_zero;
      logic idx_one;
      logic l_ok;
      logic r_ok;
      logic best_is_node;
      logic out_busy;
      logic out_last;
   } status_type;

endpackage

[design/phe_ram.sv]
module phe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/phe_datapath.sv]
module phe_datapath #(
   parameter int MAX_PAIRS = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  phe_pkg::cmd_type                    cmd,
   output phe_pkg::status_type                 status,
   input  logic                                in_fire,
   input  logic signed [phe_pkg::DATA_W-1:0]   key_x,
   input  logic signed [phe_pkg::DATA_W-1:0]   key_y,
   input  logic                                rsp_tready,
   output logic                                rsp_valid,
   output logic signed [phe_pkg::DATA_W-1:0]   out_x,
   output logic signed [phe_pkg::DATA_W-1:0]   out_y,
   output logic                                out_last,
   output logic [phe_pkg::SIFT_W-1:0]          sift_calls,
   output logic                                overflowed
);

   import phe_pkg::*;

   localparam int AW = $clog2(MAX_PAIRS);
   localparam int NW = $clog2(MAX_PAIRS + 1);
   localparam int PW = 2 * KEY_WIDTH;
   localparam logic [NW-1:0] FULL = NW'(MAX_PAIRS);

   logic [NW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [SIFT_W-1:0] sift_ff, sift_in;
   logic [NW-1:0]     idx_ff, idx_in;
   logic [NW-1:0]     node_ff, node_in;
   logic [NW-1:0]     bound_ff, bound_in;
   logic [NW-1:0]     best_idx_ff, best_idx_in;
   logic [PW-1:0]     cur_ff, cur_in;
   logic [PW-1:0]     best_ff, best_in;
   logic [PW-1:0]     tmp_ff, tmp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [DATA_W-1:0] rsp_y_ff, rsp_y_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [SIFT_W-1:0] rsp_sift_ff, rsp_sift_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [PW-1:0]     wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [PW-1:0]     rd_data;

   logic [NW:0]       child_l;
   logic [NW:0]       child_r;
   logic [NW:0]       bound_ext;
   logic signed [KEY_WIDTH-1:0] rd_x;
   logic signed [KEY_WIDTH-1:0] rd_y;

   function automatic logic [AW-1:0] node_addr(input logic [NW:0] node);
      logic [NW:0] offset;
      begin
         offset = node - 1'b1;
         return offset[AW-1:0];
      end
   endfunction

   function automatic logic pair_gt(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic signed [KEY_WIDTH-1:0] ax;
      logic signed [KEY_WIDTH-1:0] ay;
      logic signed [KEY_WIDTH-1:0] bx;
      logic signed [KEY_WIDTH-1:0] by;
      begin
         ax = a[KEY_WIDTH-1:0];
         ay = a[PW-1:KEY_WIDTH];
         bx = b[KEY_WIDTH-1:0];
         by = b[PW-1:KEY_WIDTH];
         return (ax > bx) || ((ax == bx) && (ay > by));
      end
   endfunction

   phe_ram #(
      .WIDTH(PW),
      .DEPTH(MAX_PAIRS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign child_l   = {node_ff, 1'b0};
   assign child_r   = child_l + 1'b1;
   assign bound_ext = {1'b0, bound_ff};
   assign rd_x      = rd_data[KEY_WIDTH-1:0];
   assign rd_y      = rd_data[PW-1:KEY_WIDTH];

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      sift_in      = sift_ff;
      idx_in       = idx_ff;
      node_in      = node_ff;
      bound_in     = bound_ff;
      best_idx_in  = best_idx_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_sift_in  = rsp_sift_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = {key_y[KEY_WIDTH-1:0], key_x[KEY_WIDTH-1:0]};
      rd_en        = 1'b0;
      rd_addr      = node_addr({1'b0, idx_ff});

      if (in_fire) begin
         if (count_ff != FULL) begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end

      case (cmd.op)
         OP_BUILD_INIT: begin
            idx_in = count_ff >> 1;
         end
         OP_READ_IDX: begin
            rd_en    = 1'b1;
            node_in  = idx_ff;
            bound_in = count_ff;
         end
         OP_SIFT_LOAD: begin
            cur_in = rd_data;
         end
         OP_LEVEL: begin
            if (sift_ff != SIFT_MAX) begin
               sift_in = sift_ff + 1'b1;
            end
            best_idx_in = node_ff;
            best_in     = cur_ff;
            rd_en       = status.l_ok;
            rd_addr     = node_addr(child_l);
         end
         OP_CMP_L: begin
            if (pair_gt(rd_data, best_ff)) begin
               best_in     = rd_data;
               best_idx_in = child_l[NW-1:0];
            end
            rd_en   = status.r_ok;
            rd_addr = node_addr(child_r);
         end
         OP_CMP_R: begin
            if (pair_gt(rd_data, best_ff)) begin
               best_in     = rd_data;
               best_idx_in = child_r[NW-1:0];
            end
         end
         OP_DESCEND: begin
            wr_en   = 1'b1;
            wr_addr = node_addr({1'b0, node_ff});
            if (status.best_is_node) begin
               wr_data = cur_ff;
            end else begin
               wr_data = best_ff;
               node_in = best_idx_ff;
            end
         end
         OP_IDX_DEC: begin
            idx_in = idx_ff - 1'b1;
         end
         OP_EXT_INIT: begin
            idx_in = count_ff;
         end
         OP_EXT_R1: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         OP_EXT_R2: begin
            tmp_in = rd_data;
            rd_en  = 1'b1;
         end
         OP_EXT_W: begin
            cur_in   = rd_data;
            wr_en    = 1'b1;
            wr_addr  = node_addr({1'b0, idx_ff});
            wr_data  = tmp_ff;
            node_in  = NW'(1);
            bound_in = idx_ff - 1'b1;
         end
         OP_OUT_INIT: begin
            idx_in = NW'(1);
         end
         OP_OUT_RD: begin
            rd_en = 1'b1;
         end
         OP_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_x_in     = DATA_W'(rd_x);
            rsp_y_in     = DATA_W'(rd_y);
            rsp_last_in  = status.out_last;
            rsp_sift_in  = sift_ff;
            rsp_ovf_in   = ovf_ff;
            idx_in       = idx_ff + 1'b1;
         end
         OP_CLEAR: begin
            count_in = '0;
            sift_in  = '0;
            ovf_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      status.idx_zero     = (idx_ff == '0);
      status.idx_one      = (idx_ff == NW'(1));
      status.l_ok         = (child_l <= bound_ext);
      status.r_ok         = (child_r <= bound_ext);
      status.best_is_node = (best_idx_ff == node_ff);
      status.out_busy     = rsp_valid_ff;
      status.out_last     = (idx_ff == count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sift_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sift_ff      <= sift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      node_ff     <= node_in;
      bound_ff    <= bound_in;
      best_idx_ff <= best_idx_in;
      cur_ff      <= cur_in;
      best_ff     <= best_in;
      tmp_ff      <= tmp_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
      rsp_sift_ff <= rsp_sift_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign out_x      = rsp_x_ff;
   assign out_y      = rsp_y_ff;
   assign out_last   = rsp_last_ff;
   assign sift_calls = rsp_sift_ff;
   assign overflowed = rsp_ovf_ff;

endmodule

[design/phe_ctrl.sv]
module phe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_fire,
   input  logic                in_last,
   input  phe_pkg::status_type status,
   output phe_pkg::cmd_type    cmd
);

   import phe_pkg::*;

   typedef enum logic [4:0] {
      S_LOAD,
      S_BUILD_INIT,
      S_BUILD_CHK,
      S_SIFT_LOAD,
      S_LEVEL,
      S_CMP_L,
      S_CMP_R,
      S_DESCEND,
      S_BUILD_NEXT,
      S_EXT_INIT,
      S_EXT_R1,
      S_EXT_R2,
      S_EXT_W,
      S_EXT_NEXT,
      S_EXT_CHK,
      S_OUT_RD,
      S_OUT_LD,
      S_CLEAR
   } state_type;

   state_type state_ff, state_in;
   logic      extract_ff, extract_in;

   always_comb begin
      state_in     = state_ff;
      extract_in   = extract_ff;
      cmd.op       = OP_NONE;
      cmd.in_ready = 1'b0;

      case (state_ff)
         S_LOAD: begin
            cmd.in_ready = 1'b1;
            if (in_fire && in_last) begin
               state_in = S_BUILD_INIT;
            end
         end
         S_BUILD_INIT: begin
            cmd.op   = OP_BUILD_INIT;
            state_in = S_BUILD_CHK;
         end
         S_BUILD_CHK: begin
            if (status.idx_zero) begin
               state_in = S_EXT_INIT;
            end else begin
               cmd.op     = OP_READ_IDX;
               extract_in = 1'b0;
               state_in   = S_SIFT_LOAD;
            end
         end
         S_SIFT_LOAD: begin
            cmd.op   = OP_SIFT_LOAD;
            state_in = S_LEVEL;
         end
         S_LEVEL: begin
            cmd.op   = OP_LEVEL;
            state_in = status.l_ok ? S_CMP_L : S_DESCEND;
         end
         S_CMP_L: begin
            cmd.op   = OP_CMP_L;
            state_in = status.r_ok ? S_CMP_R : S_DESCEND;
         end
         S_CMP_R: begin
            cmd.op   = OP_CMP_R;
            state_in = S_DESCEND;
         end
         S_DESCEND: begin
            cmd.op = OP_DESCEND;
            if (!status.best_is_node) begin
               state_in = S_LEVEL;
            end else if (extract_ff) begin
               state_in = S_EXT_NEXT;
            end else begin
               state_in = S_BUILD_NEXT;
            end
         end
         S_BUILD_NEXT: begin
            cmd.op   = OP_IDX_DEC;
            state_in = S_BUILD_CHK;
         end
         S_EXT_INIT: begin
            cmd.op   = OP_EXT_INIT;
            state_in = S_EXT_R1;
         end
         S_EXT_R1: begin
            cmd.op   = OP_EXT_R1;
            state_in = S_EXT_R2;
         end
         S_EXT_R2: begin
            cmd.op   = OP_EXT_R2;
            state_in = S_EXT_W;
         end
         S_EXT_W: begin
            cmd.op     = OP_EXT_W;
            extract_in = 1'b1;
            state_in   = status.idx_one ? S_EXT_NEXT : S_LEVEL;
         end
         S_EXT_NEXT: begin
            cmd.op   = OP_IDX_DEC;
            state_in = S_EXT_CHK;
         end
         S_EXT_CHK: begin
            if (status.idx_zero) begin
               cmd.op   = OP_OUT_INIT;
               state_in = S_OUT_RD;
            end else begin
               state_in = S_EXT_R1;
            end
         end
         S_OUT_RD: begin
            cmd.op   = OP_OUT_RD;
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            if (!status.out_busy) begin
               cmd.op   = OP_OUT_LD;
               state_in = status.out_last ? S_CLEAR : S_OUT_RD;
            end
         end
         S_CLEAR: begin
            cmd.op   = OP_CLEAR;
            state_in = S_LOAD;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         extract_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         extract_ff <= extract_in;
      end
   end

endmodule

[design/pair_heapsort_engine_top.sv]
// Heapsort engine for sets of signed (x, y) pairs. Pairs are loaded one per cycle on the
// request stream while it is open, and the transaction with tlast high closes the set. Up
// to MAX_PAIRS pairs are kept; later pairs of the set are dropped and the results report
// it in tuser. The set is then turned into a max-heap and sorted in place in a store with
// one read port and one write port, so each level of a sift-down reads the two children
// one after the other through that store's one read port. Results leave in ascending
// order, each loaded once the sink has taken the previous one, and each carrying the
// number of sift-down levels spent on the set. The request stream is closed from the
// final pair until the greatest result has been loaded into the output register; the
// next set may load while that result waits.
module pair_heapsort_engine_top #(
   parameter int MAX_PAIRS = phe_pkg::MAX_PAIRS_DEF,
   parameter int KEY_WIDTH = phe_pkg::KEY_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // key_x [31:0], key_y [63:32]
   input  logic [phe_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_x [31:0], out_y [63:32], sift_calls [73:64], zero [79:74]
   output logic [phe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // overflowed [0]
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);

   import phe_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic              in_fire;
   logic signed [DATA_W-1:0] out_x;
   logic signed [DATA_W-1:0] out_y;
   logic [SIFT_W-1:0] sift_calls;

   assign req_tready = cmd.in_ready & ~reset;
   assign in_fire    = req_tvalid & req_tready;

   phe_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .in_fire(in_fire),
      .in_last(req_tlast),
      .status (status),
      .cmd    (cmd)
   );

   phe_datapath #(
      .MAX_PAIRS(MAX_PAIRS),
      .KEY_WIDTH(KEY_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_fire   (in_fire),
      .key_x     (req_tdata[DATA_W-1:0]),
      .key_y     (req_tdata[2*DATA_W-1:DATA_W]),
      .rsp_tready(rsp_tready),
      .rsp_valid (rsp_tvalid),
      .out_x     (out_x),
      .out_y     (out_y),
      .out_last  (rsp_tlast),
      .sift_calls(sift_calls),
      .overflowed(rsp_tuser)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, sift_calls, out_y, out_x};

endmodule

[design/phe_checker.sv]
module phe_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic                           rsp_tlast,
   input logic [phe_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // The final pair of a set closes the request stream for the sort.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("request accepted right after the final pair");

   // No new pair is taken while results of the set are still to come.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request stream open during result delivery");

   // After a result that is not the last, the request stream stays closed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready)
      else $error("request stream reopened before the greatest result");

endmodule

bind pair_heapsort_engine_top phe_checker u_phe_checker (.*);
